@@ src/ptss_pkg.sv @@
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types and constants for the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

  localparam int TimelineSlotsDef = 64;
  localparam int TaskIdBitsDef    = 8;

  localparam int LenW    = 7;   // schedule length, slot counters
  localparam int TimeW   = 16;  // period and duration
  localparam int LoW     = 17;  // window start, holds start plus one period
  localparam int SlotW   = 6;   // slot_time field
  localparam int PerIdxW = 6;   // period_index field
  localparam int KindW   = 2;

  localparam logic [LenW-1:0] SchedLenRst = 7'd64;

  // Event kinds
  localparam logic [KindW-1:0] EvStart    = 2'd0;
  localparam logic [KindW-1:0] EvContinue = 2'd1;
  localparam logic [KindW-1:0] EvFailed   = 2'd2;
  localparam logic [KindW-1:0] EvRejected = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take a new task
    logic win;       // set up the current period window
    logic chk;       // count one slot in the check pass
    logic clm_init;  // restart the scan for the claim pass
    logic clm;       // examine one slot in the claim pass
    logic fail;      // post a period-failed event
    logic next;      // advance to the next window
    logic flush;     // send the held event as the last one
  } ptss_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_bad;    // offered task is invalid
    logic win_done;  // window start at or past the runtime
    logic chk_more;  // check pass still scanning
    logic fit;       // window has enough free slots
    logic clm_more;  // claim pass still scanning
    logic clm_emit;  // current claim slot posts an event
    logic can_emit;  // an event can be posted this cycle
    logic out_free;  // output register can be loaded
  } ptss_sts_t;

endpackage

@@ src/ptss_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptss_ctrl
// Sequencer for the scheduler: steps each task through its period windows.
// ----------------------------------------------------------------------------
module ptss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptss_pkg::ptss_sts_t sts_i,
  output ptss_pkg::ptss_cmd_t cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SWin   = 3'd1;
  localparam logic [2:0] SCheck = 3'd2;
  localparam logic [2:0] SFail  = 3'd3;
  localparam logic [2:0] SClaim = 3'd4;
  localparam logic [2:0] SFlush = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_bad ? SFlush : SWin;
        end
      end
      SWin: begin
        if (sts_i.win_done) begin
          state_d = SFlush;
        end else begin
          cmd_o.win = 1'b1;
          state_d   = SCheck;
        end
      end
      SCheck: begin
        if (sts_i.chk_more) begin
          cmd_o.chk = 1'b1;
        end else if (sts_i.fit) begin
          cmd_o.clm_init = 1'b1;
          state_d        = SClaim;
        end else begin
          state_d = SFail;
        end
      end
      SFail: begin
        if (sts_i.can_emit) begin
          cmd_o.fail = 1'b1;
          cmd_o.next = 1'b1;
          state_d    = SWin;
        end
      end
      SClaim: begin
        if (sts_i.clm_more) begin
          // hold while an event is due and the output side is full
          if (!sts_i.clm_emit || sts_i.can_emit) begin
            cmd_o.clm = 1'b1;
          end
        end else begin
          cmd_o.next = 1'b1;
          state_d    = SWin;
        end
      end
      SFlush: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/ptss_dp.sv @@
// ----------------------------------------------------------------------------
// ptss_dp
// Datapath: occupancy bitmap, window and slot counters, event holding and
// output registers.
// ----------------------------------------------------------------------------
module ptss_dp #(
  parameter int TIMELINE_SLOTS = ptss_pkg::TimelineSlotsDef,
  parameter int TASK_ID_BITS   = ptss_pkg::TaskIdBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptss_pkg::LenW-1:0]     cfg_wdata_i,
  input  logic                          new_schedule_i,
  input  logic [TASK_ID_BITS-1:0]       task_id_i,
  input  logic [ptss_pkg::TimeW-1:0]    task_period_i,
  input  logic [ptss_pkg::TimeW-1:0]    task_duration_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ptss_pkg::KindW-1:0]    event_kind_o,
  output logic [ptss_pkg::SlotW-1:0]    slot_time_o,
  output logic [ptss_pkg::PerIdxW-1:0]  period_index_o,
  output logic [TASK_ID_BITS-1:0]       event_task_o,
  output logic                          last_event_o,
  input  ptss_pkg::ptss_cmd_t           cmd_i,
  output ptss_pkg::ptss_sts_t           sts_o
);

  localparam int IdxW = (TIMELINE_SLOTS > 1) ? $clog2(TIMELINE_SLOTS) : 1;
  localparam logic [ptss_pkg::LenW-1:0] SlotsMax = ptss_pkg::LenW'(TIMELINE_SLOTS);

  logic [TIMELINE_SLOTS-1:0]        busy_q;
  logic [ptss_pkg::LenW-1:0]        sched_len_q;
  logic [ptss_pkg::LenW-1:0]        runtime_q;
  logic [TASK_ID_BITS-1:0]          task_q;
  logic [ptss_pkg::TimeW-1:0]       period_q;
  logic [ptss_pkg::TimeW-1:0]       dur_q;
  logic [ptss_pkg::LoW-1:0]         lo_q;
  logic [ptss_pkg::LenW-1:0]        hi_q;
  logic [ptss_pkg::LenW-1:0]        j_q;
  logic [ptss_pkg::LenW-1:0]        free_q;
  logic [ptss_pkg::LenW-1:0]        need_q;
  logic [ptss_pkg::PerIdxW-1:0]     idx_q;
  logic                             started_q;
  logic                             gap_q;
  logic                             pend_valid_q;
  logic [ptss_pkg::KindW-1:0]       pend_kind_q;
  logic [ptss_pkg::SlotW-1:0]       pend_slot_q;
  logic [ptss_pkg::PerIdxW-1:0]     pend_idx_q;
  logic                             out_valid_q;
  logic [ptss_pkg::KindW-1:0]       out_kind_q;
  logic [ptss_pkg::SlotW-1:0]       out_slot_q;
  logic [ptss_pkg::PerIdxW-1:0]     out_idx_q;
  logic [TASK_ID_BITS-1:0]          out_task_q;
  logic                             out_last_q;

  logic [ptss_pkg::LoW-1:0]         win_sum;
  logic [ptss_pkg::LenW-1:0]        win_hi;
  logic [ptss_pkg::LenW-1:0]        runtime_d;
  logic                             cur_free;
  logic                             emit_en;
  logic [ptss_pkg::KindW-1:0]       emit_kind;
  logic [ptss_pkg::SlotW-1:0]       emit_slot;
  logic                             out_load;

  assign win_sum  = lo_q + ptss_pkg::LoW'(period_q);
  assign win_hi   = (win_sum > ptss_pkg::LoW'(runtime_q)) ? runtime_q
                                                          : win_sum[ptss_pkg::LenW-1:0];
  assign cur_free = !busy_q[j_q[IdxW-1:0]];

  always_comb begin
    if (sched_len_q == '0) begin
      runtime_d = ptss_pkg::LenW'(1);
    end else if (sched_len_q > SlotsMax) begin
      runtime_d = SlotsMax;
    end else begin
      runtime_d = sched_len_q;
    end
  end

  // Status
  assign sts_o.in_bad   = (task_period_i == '0) || (task_duration_i == '0) ||
                          (task_duration_i > task_period_i);
  assign sts_o.win_done = (lo_q >= ptss_pkg::LoW'(runtime_q));
  assign sts_o.chk_more = (j_q < hi_q) && (ptss_pkg::TimeW'(free_q) < dur_q);
  assign sts_o.fit      = (ptss_pkg::TimeW'(free_q) >= dur_q);
  assign sts_o.clm_more = (j_q < hi_q) && (need_q != '0);
  assign sts_o.clm_emit = cur_free && (!started_q || gap_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.can_emit = !pend_valid_q || sts_o.out_free;

  assign emit_en   = cmd_i.fail || (cmd_i.clm && sts_o.clm_emit);
  assign emit_kind = cmd_i.fail ? ptss_pkg::EvFailed
                   : (started_q ? ptss_pkg::EvContinue : ptss_pkg::EvStart);
  assign emit_slot = cmd_i.fail ? '0 : j_q[ptss_pkg::SlotW-1:0];
  assign out_load  = (emit_en && pend_valid_q) || cmd_i.flush;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_len_q  <= ptss_pkg::SchedLenRst;
      busy_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sched_len_q <= cfg_wdata_i;
      end
      if (cmd_i.load && new_schedule_i) begin
        busy_q <= '0;
      end else if (cmd_i.clm && cur_free) begin
        busy_q[j_q[IdxW-1:0]] <= 1'b1;
      end
      if (cmd_i.load) begin
        pend_valid_q <= sts_o.in_bad;
      end else if (emit_en) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      task_q    <= task_id_i;
      period_q  <= task_period_i;
      dur_q     <= task_duration_i;
      runtime_q <= runtime_d;
      lo_q      <= '0;
      idx_q     <= '0;
      if (sts_o.in_bad) begin
        pend_kind_q <= ptss_pkg::EvRejected;
        pend_slot_q <= '0;
        pend_idx_q  <= '0;
      end
    end
    if (cmd_i.win) begin
      hi_q      <= win_hi;
      j_q       <= lo_q[ptss_pkg::LenW-1:0];
      free_q    <= '0;
      started_q <= 1'b0;
      gap_q     <= 1'b0;
    end
    if (cmd_i.chk) begin
      if (cur_free) begin
        free_q <= free_q + ptss_pkg::LenW'(1);
      end
      j_q <= j_q + ptss_pkg::LenW'(1);
    end
    if (cmd_i.clm_init) begin
      j_q    <= lo_q[ptss_pkg::LenW-1:0];
      need_q <= dur_q[ptss_pkg::LenW-1:0];
    end
    if (cmd_i.clm) begin
      if (cur_free) begin
        need_q    <= need_q - ptss_pkg::LenW'(1);
        started_q <= 1'b1;
        gap_q     <= 1'b0;
      end else if (started_q) begin
        gap_q <= 1'b1;
      end
      j_q <= j_q + ptss_pkg::LenW'(1);
    end
    if (cmd_i.next) begin
      lo_q  <= win_sum;
      idx_q <= idx_q + ptss_pkg::PerIdxW'(1);
    end
    if (emit_en) begin
      pend_kind_q <= emit_kind;
      pend_slot_q <= emit_slot;
      pend_idx_q  <= idx_q;
    end
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_slot_q <= pend_slot_q;
      out_idx_q  <= pend_idx_q;
      out_task_q <= task_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_kind_q;
  assign slot_time_o    = out_slot_q;
  assign period_index_o = out_idx_q;
  assign event_task_o   = out_task_q;
  assign last_event_o   = out_last_q;

endmodule

@@ src/periodic_task_slot_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_top
// Fixed-priority periodic time-slot scheduler: places one periodic task per
// transaction into a slot occupancy bitmap and reports start, continue,
// period-failed and rejected events.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+--------------------------------
//  cfg     | in        | cfg_we_i (no wait)       | cfg_wdata_i = schedule_length
//  in      | in        | in_valid_i / in_ready_o  | new_schedule, task_id, period,
//          |           |                          | duration
//  out     | out       | out_valid_o / out_ready_i| event_kind, slot_time,
//          |           |                          | period_index, event_task, last
//
//  Flow: one task at a time. One slot of the bitmap is scanned per cycle, in a
//  check pass and then a claim pass of each period window; the claim pass
//  holds on a slot whose event is due while the output side is full. The
//  single slot scan counter over the occupancy bitmap sets the scan pace.
//  Reset: asynchronous, active low; clears the bitmap, sets schedule_length to
//  64 and drops any event in flight.
//  Stalls: a full output register holds the scan only when a new event is due;
//  in_ready_o rises again as soon as the last event of a task is loaded into
//  the output register.
//
module periodic_task_slot_scheduler_top #(
  parameter int TIMELINE_SLOTS = ptss_pkg::TimelineSlotsDef,
  parameter int TASK_ID_BITS   = ptss_pkg::TaskIdBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ptss_pkg::LenW-1:0]     cfg_wdata_i,
  // task input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          new_schedule_i,
  input  logic [TASK_ID_BITS-1:0]       task_id_i,
  input  logic [ptss_pkg::TimeW-1:0]    task_period_i,
  input  logic [ptss_pkg::TimeW-1:0]    task_duration_i,
  // event output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptss_pkg::KindW-1:0]    event_kind_o,
  output logic [ptss_pkg::SlotW-1:0]    slot_time_o,
  output logic [ptss_pkg::PerIdxW-1:0]  period_index_o,
  output logic [TASK_ID_BITS-1:0]       event_task_o,
  output logic                          last_event_o
);

  ptss_pkg::ptss_cmd_t cmd;
  ptss_pkg::ptss_sts_t sts;

  // Sequencer: window loop, check pass, claim pass, final flush
  ptss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Bitmap, counters and the one-event lookahead that marks the last event
  ptss_dp #(
    .TIMELINE_SLOTS (TIMELINE_SLOTS),
    .TASK_ID_BITS   (TASK_ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .new_schedule_i  (new_schedule_i),
    .task_id_i       (task_id_i),
    .task_period_i   (task_period_i),
    .task_duration_i (task_duration_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .event_kind_o    (event_kind_o),
    .slot_time_o     (slot_time_o),
    .period_index_o  (period_index_o),
    .event_task_o    (event_task_o),
    .last_event_o    (last_event_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ src/ptss_chk.sv @@
// ----------------------------------------------------------------------------
// ptss_chk
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ptss_chk #(
  parameter int TASK_ID_BITS = ptss_pkg::TaskIdBitsDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ptss_pkg::KindW-1:0]    event_kind_o,
  input logic [ptss_pkg::SlotW-1:0]    slot_time_o,
  input logic [ptss_pkg::PerIdxW-1:0]  period_index_o,
  input logic [TASK_ID_BITS-1:0]       event_task_o,
  input logic                          last_event_o
);

  // A stalled event holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(slot_time_o) && $stable(period_index_o) &&
      $stable(event_task_o) && $stable(last_event_o))
    else $error("stalled event changed");

  // Only one task at a time is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("task accepted while another is in work");

  // A rejected task gives one closing event with zero slot and period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == ptss_pkg::EvRejected) |->
      last_event_o && (slot_time_o == '0) && (period_index_o == '0))
    else $error("malformed rejected event");

  // A failed period carries slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == ptss_pkg::EvFailed) |-> (slot_time_o == '0))
    else $error("failed event with nonzero slot");

endmodule

bind periodic_task_slot_scheduler_top ptss_chk #(
  .TASK_ID_BITS (TASK_ID_BITS)
) u_ptss_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_kind_o   (event_kind_o),
  .slot_time_o    (slot_time_o),
  .period_index_o (period_index_o),
  .event_task_o   (event_task_o),
  .last_event_o   (last_event_o)
);

@@ bench/periodic_task_slot_scheduler_top_test.sv @@
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_top_test
// Self-checking bench for the periodic task slot scheduler. A driver offers
// tasks from a backlog that the stimulus process fills. A monitor takes the
// events and checks each one against a slot-placement predictor that keeps
// its own occupancy map. Both sides idle at random. The run covers every
// schedule length class, a long receiver hold-off and full drains between
// phases.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimelineSlots = ptss_pkg::TimelineSlotsDef;
  localparam int IdW           = ptss_pkg::TaskIdBitsDef;
  localparam int HoldCycles    = 400;   // long receiver hold-off
  localparam int StuckLimit    = 4000;  // cycles with no transaction at all
  localparam int TailCycles    = 300;   // settle time after the last event

  typedef struct packed {
    logic                       fresh;   // clear the slot map first
    logic [IdW-1:0]             id;
    logic [ptss_pkg::TimeW-1:0] period;
    logic [ptss_pkg::TimeW-1:0] dur;
  } task_item_t;

  typedef struct packed {
    logic [ptss_pkg::KindW-1:0]   kind;
    logic [ptss_pkg::SlotW-1:0]   slot;
    logic [ptss_pkg::PerIdxW-1:0] pidx;
    logic [IdW-1:0]               id;
    logic                         last;
  } slot_event_t;

  // DUT ports; every input starts at a known value
  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [ptss_pkg::LenW-1:0]    cfg_wdata_i     = '0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_ready_o;
  logic                         new_schedule_i  = 1'b0;
  logic [IdW-1:0]               task_id_i       = '0;
  logic [ptss_pkg::TimeW-1:0]   task_period_i   = '0;
  logic [ptss_pkg::TimeW-1:0]   task_duration_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i     = 1'b0;
  logic [ptss_pkg::KindW-1:0]   event_kind_o;
  logic [ptss_pkg::SlotW-1:0]   slot_time_o;
  logic [ptss_pkg::PerIdxW-1:0] period_index_o;
  logic [IdW-1:0]               event_task_o;
  logic                         last_event_o;

  // Predictor state: occupancy map and schedule length as last written
  logic [TimelineSlots-1:0]  slot_map = '0;
  logic [ptss_pkg::LenW-1:0] run_len  = ptss_pkg::SchedLenRst;

  task_item_t  task_backlog[$];  // tasks not yet offered
  slot_event_t due_events[$];    // events predicted but not yet taken

  task_item_t offered;
  bit         tx_busy;
  int         tx_wait = 0;
  int         rx_wait = 0;
  bit         no_idle = 1'b0;    // phase runs both sides flat out
  bit         hold_armed = 1'b0; // next taken event starts the long hold-off
  bit         hold_done = 1'b0;  // long hold-off already spent
  int         mismatches = 0;
  int         stuck_cycles = 0;

  periodic_task_slot_scheduler_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .new_schedule_i (new_schedule_i),
    .task_id_i      (task_id_i),
    .task_period_i  (task_period_i),
    .task_duration_i(task_duration_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .slot_time_o    (slot_time_o),
    .period_index_o (period_index_o),
    .event_task_o   (event_task_o),
    .last_event_o   (last_event_o)
  );

  always #10 clk_i = ~clk_i;

  // Random idle length for either side; none while a flat-out phase runs.
  function automatic int pause_len();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // Place one task on the slot map and append the events it causes.
  function automatic void place_task(task_item_t t);
    slot_event_t evs[$];
    slot_event_t ev;
    int span, per, need, win, lo, hi, j, free_n, still_needed;
    bit started, in_gap;
    span = (run_len == 0) ? 1 : ((run_len > TimelineSlots) ? TimelineSlots : run_len);
    per  = t.period;
    need = t.dur;
    // Clear happens even for a task that is then rejected
    if (t.fresh) slot_map = '0;
    ev    = '0;
    ev.id = t.id;
    if (per == 0 || need == 0 || need > per) begin
      ev.kind = ptss_pkg::EvRejected;
      ev.last = 1'b1;
      due_events = {due_events, ev};
      return;
    end
    // Walk each period window, clipped to the schedule length
    for (win = 0; win * per < span; win++) begin
      lo = win * per;
      hi = lo + per;
      if (hi > span) hi = span;
      ev.pidx = win[ptss_pkg::PerIdxW-1:0];
      ev.slot = '0;
      free_n  = 0;
      for (j = lo; j < hi; j++)
        if (!slot_map[j]) free_n++;
      if (free_n < need) begin
        ev.kind = ptss_pkg::EvFailed;
        evs = {evs, ev};
        continue;
      end
      // Claim the earliest free slots; report the first and each one after a gap
      started      = 1'b0;
      in_gap       = 1'b0;
      still_needed = need;
      for (j = lo; j < hi && still_needed > 0; j++) begin
        if (!slot_map[j]) begin
          if (!started || in_gap) begin
            ev.kind = started ? ptss_pkg::EvContinue : ptss_pkg::EvStart;
            ev.slot = j[ptss_pkg::SlotW-1:0];
            evs = {evs, ev};
          end
          started     = 1'b1;
          in_gap      = 1'b0;
          slot_map[j] = 1'b1;
          still_needed--;
        end else if (started) begin
          in_gap = 1'b1;
        end
      end
    end
    evs[$].last = 1'b1;
    due_events = {due_events, evs};
  endfunction

  // Random task: mostly small periods that place well, some long periods,
  // and a share of malformed tasks.
  function automatic task_item_t make_task(bit fresh);
    task_item_t t;
    int pick, per;
    pick    = $urandom_range(0, 19);
    t.fresh = fresh;
    t.id    = IdW'($urandom_range(0, (1 << IdW) - 1));
    if (pick < 14) begin
      per      = $urandom_range(1, 24);
      t.period = ptss_pkg::TimeW'(per);
      t.dur    = ptss_pkg::TimeW'($urandom_range(0, 2) == 0 ? $urandom_range(1, per)
                                                            : $urandom_range(1, (per + 3) / 4));
    end else if (pick < 16) begin
      per      = $urandom_range(0, 1) ? $urandom_range(25, 80) : $urandom_range(25, 65535);
      t.period = ptss_pkg::TimeW'(per);
      t.dur    = ptss_pkg::TimeW'($urandom_range(0, 1) ? $urandom_range(1, (per < 64) ? per : 64)
                                                       : $urandom_range(1, per));
    end else if (pick == 16) begin
      t.period = '0;
      t.dur    = ptss_pkg::TimeW'($urandom_range(0, 65535));
    end else if (pick == 17) begin
      t.period = ptss_pkg::TimeW'($urandom_range(1, 65535));
      t.dur    = '0;
    end else if (pick == 18) begin
      per      = $urandom_range(1, 65534);
      t.period = ptss_pkg::TimeW'(per);
      t.dur    = ptss_pkg::TimeW'($urandom_range(per + 1, 65535));
    end else begin
      t.period = ptss_pkg::TimeW'($urandom_range(0, 65535));
      t.dur    = ptss_pkg::TimeW'($urandom_range(0, 65535));
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the backlog one task at a time. Hold valid and payload until
  // the transaction is taken, then wait a random gap before the next task.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_tasks
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      tx_busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        place_task(offered);
        tx_busy = 1'b0;
        tx_wait = pause_len();
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (task_backlog.size() != 0) begin
          offered = task_backlog.pop_front();
          new_schedule_i  <= offered.fresh;
          task_id_i       <= offered.id;
          task_period_i   <= offered.period;
          task_duration_i <= offered.dur;
          tx_busy = 1'b1;
        end
      end
      // One assignment per edge, so a back-to-back task keeps valid high
      in_valid_i <= tx_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take events, compare each against the oldest prediction, then
  // drop ready for a random stall, or for the long hold-off when armed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : take_events
    slot_event_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_events.size() == 0) begin
          $error("event with nothing predicted: kind %0d slot %0d period %0d task %0d",
                 event_kind_o, slot_time_o, period_index_o, event_task_o);
          mismatches++;
        end else begin
          want = due_events.pop_front();
          if (event_kind_o !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, event_kind_o);
            mismatches++;
          end
          if (slot_time_o !== want.slot) begin
            $error("slot_time: expected %0d, actual %0d", want.slot, slot_time_o);
            mismatches++;
          end
          if (period_index_o !== want.pidx) begin
            $error("period_index: expected %0d, actual %0d", want.pidx, period_index_o);
            mismatches++;
          end
          if (event_task_o !== want.id) begin
            $error("event_task: expected %0d, actual %0d", want.id, event_task_o);
            mismatches++;
          end
          if (last_event_o !== want.last) begin
            $error("last_event: expected %0d, actual %0d", want.last, last_event_o);
            mismatches++;
          end
        end
        if (hold_armed && !hold_done) begin
          rx_wait   = HoldCycles;
          hold_done = 1'b1;
        end else begin
          rx_wait = pause_len();
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Wait until every task is taken and every predicted event has come back.
  task automatic drain();
    do @(negedge clk_i);
    while (task_backlog.size() != 0 || in_valid_i || due_events.size() != 0);
  endtask

  // Write the schedule length; only called while the block is idle.
  task automatic set_length(logic [ptss_pkg::LenW-1:0] len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    run_len = len;
  endtask

  task automatic queue_task(bit fresh, int id, int per, int dur);
    task_item_t t;
    t.fresh  = fresh;
    t.id     = IdW'(id);
    t.period = ptss_pkg::TimeW'(per);
    t.dur    = ptss_pkg::TimeW'(dur);
    task_backlog = {task_backlog, t};
  endtask

  // One phase: drain, write the length, then queue task sets that each open
  // with a fresh schedule followed by tasks placed on top of it.
  task automatic run_phase(logic [ptss_pkg::LenW-1:0] len, int count, bit flat, bit hold);
    int done_n, set_n;
    drain();
    set_length(len);
    @(negedge clk_i);
    no_idle    = flat;
    hold_armed = hold;
    done_n     = 0;
    while (done_n < count) begin
      set_n = $urandom_range(1, 8);
      for (int i = 0; i < set_n && done_n < count; i++) begin
        task_backlog = {task_backlog, make_task(i == 0)};
        done_n++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_length(ptss_pkg::SchedLenRst);
    @(negedge clk_i);

    // Malformed tasks: zero period, zero duration, duration past the period
    queue_task(1'b1, 8'h00, 0, 0);
    queue_task(1'b0, 8'hFF, 5, 0);
    queue_task(1'b0, 8'h5A, 3, 4);
    // One window covering the whole timeline that cannot fit
    queue_task(1'b0, 8'hA5, 16'hFFFF, 16'hFFFF);
    // Fill everything, then every one-slot window fails: most events per task
    queue_task(1'b1, 1, 64, 64);
    queue_task(1'b0, 2, 1, 1);
    // Fresh map, one-slot windows: a start in every window
    queue_task(1'b1, 3, 1, 1);
    // Gaps in the claim pass raise continue events
    queue_task(1'b1, 4, 8, 2);
    queue_task(1'b0, 5, 16, 10);
    queue_task(1'b0, 6, 65535, 1);
    queue_task(1'b0, 7, 100, 50);
    queue_task(1'b0, 8, 16'hFFFE, 16'hFFFF);
    queue_task(1'b1, 9, 16'h8000, 1);
    // Last window clipped short of the period
    queue_task(1'b0, 10, 5, 5);
    queue_task(1'b0, 11, 3, 1);
    queue_task(1'b1, 12, 64, 1);
    queue_task(1'b0, 13, 64, 63);
    queue_task(1'b0, 14, 64, 1);
    queue_task(1'b1, 15, 2, 1);
    queue_task(1'b0, 16, 4, 2);
    queue_task(1'b1, 17, 65535, 64);
    queue_task(1'b0, 18, 0, 65535);
    // Rejected task still clears the map, so the full claim after it fits
    queue_task(1'b1, 19, 0, 16'h8000);
    queue_task(1'b0, 20, 64, 64);

    run_phase(7'd64, 60, 1'b1, 1'b0);
    run_phase(7'd1, 30, 1'b0, 1'b0);
    run_phase(7'd0, 20, 1'b0, 1'b0);
    // Hold off the receiver while tasks keep coming, so the input stalls
    run_phase(7'd127, 60, 1'b0, 1'b1);
    for (int p = 0; p < 6; p++)
      run_phase(ptss_pkg::LenW'($urandom_range(0, 127)), 48, $urandom_range(0, 3) == 0,
                1'b0);
    drain();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ptss_pkg.sv
src/ptss_ctrl.sv
src/ptss_dp.sv
src/periodic_task_slot_scheduler_top.sv
src/ptss_chk.sv
bench/periodic_task_slot_scheduler_top_test.sv
